@@ rtl/lpsp_pkg.sv @@
// ----------------------------------------------------------------------------
// LiDAR packet stream parser package
// Shared types, sync bytes, header layout and configuration register codes.
// ----------------------------------------------------------------------------
package lpsp_pkg;

    // Default header length in bytes, sync word included.
    localparam int HEADER_BYTES_DEF = 16;

    // Sync word "HISN".
    localparam logic [7:0] SYNC0 = 8'h48;
    localparam logic [7:0] SYNC1 = 8'h49;
    localparam logic [7:0] SYNC2 = 8'h53;
    localparam logic [7:0] SYNC3 = 8'h4E;

    // Header byte offsets of the big-endian fields.
    localparam int HDR_FIRST       = 4;
    localparam int HDR_START_HI    = 4;
    localparam int HDR_START_LO    = 5;
    localparam int HDR_END_HI      = 6;
    localparam int HDR_END_LO      = 7;
    localparam int HDR_COUNT_HI    = 8;
    localparam int HDR_COUNT_LO    = 9;
    localparam int HDR_POS_HI      = 10;
    localparam int HDR_POS_LO      = 11;
    localparam int HDR_TOTAL_HI    = 12;
    localparam int HDR_TOTAL_LO    = 13;

    // Point byte offsets within a 4-byte point record.
    localparam logic [1:0] PT_DIST_LO = 2'd0;
    localparam logic [1:0] PT_DIST_HI = 2'd1;
    localparam logic [1:0] PT_INT_LO  = 2'd2;
    localparam logic [1:0] PT_INT_HI  = 2'd3;

    // Configuration registers.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTENSITY = 1'd1;

    // One input byte of the stream.
    typedef struct packed {
        logic [7:0] data_byte;
    } byte_item_t;

    // One parsed point result.
    typedef struct packed {
        logic        point_valid;
        logic [15:0] distance;
        logic [15:0] intensity;
        logic [15:0] point_index;
        logic [15:0] start_ang;
        logic        last_in_packet;
        logic        scan_complete;
    } point_item_t;

endpackage

@@ rtl/lpsp_stream_if.sv @@
// ----------------------------------------------------------------------------
// LiDAR packet stream parser channel interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lpsp_stream_if #(
    parameter type payload_t = lpsp_pkg::byte_item_t
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

@@ rtl/lidar_packet_stream_parser_top.sv @@
// ----------------------------------------------------------------------------
// LiDAR packet stream parser top level
// Byte stream in, one point result per 4-byte point record out.
// ----------------------------------------------------------------------------
// Usage:
// byte_in carries one stream byte per transaction. point_out carries one
// parsed point per transaction, or a single result with point_valid low for
// a packet whose clamped point count is zero. The block hunts for the "HISN"
// sync word, reads the HEADER_BYTES-long header and then takes 4-byte points.
// Throughput is one byte per cycle while point_out does not stall: the parser
// decodes a byte combinationally between the input register and the result
// register. A result reaches point_out through both registers after the byte
// transaction that completes a point (or the header of an empty packet).
// The write port sets max_distance and max_intensity; write it while idle.
// Reset clears the parser to the sync hunt, empties both registers and sets
// both maxima to 65535. When point_out stalls, a waiting result holds and the
// input register still takes one more byte; byte_in.ready then drops until
// the result is taken.
// ----------------------------------------------------------------------------
module lidar_packet_stream_parser_top #(
    parameter int HEADER_BYTES = lpsp_pkg::HEADER_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lpsp_stream_if.sink                       byte_in,
    lpsp_stream_if.source                     point_out,
    input  logic                              cfg_we,
    input  logic [lpsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpsp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                  byte_valid;
    logic [7:0]            byte_data;
    logic                  advance;
    logic [15:0]           max_distance_reg;
    logic [15:0]           max_intensity_reg;
    lpsp_pkg::point_item_t res_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_distance_reg  <= 16'hFFFF;
            max_intensity_reg <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpsp_pkg::CFG_MAX_DISTANCE:  max_distance_reg  <= cfg_data;
                lpsp_pkg::CFG_MAX_INTENSITY: max_intensity_reg <= cfg_data;
                default:                     max_distance_reg  <= max_distance_reg;
            endcase
        end
    end

    // Input register.
    lpsp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // Parser with result register.
    lpsp_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .max_distance  (max_distance_reg),
        .max_intensity (max_intensity_reg),
        .byte_valid    (byte_valid),
        .byte_data     (byte_data),
        .advance       (advance),
        .res_ready     (point_out.ready),
        .res_valid     (point_out.valid),
        .res_data      (res_data)
    );

    assign point_out.payload = res_data;

    // A result without a point always closes its packet.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        point_out.valid && !point_out.payload.point_valid
        |-> point_out.payload.last_in_packet)
        else $error("empty-packet result not marked last");

    // Scan complete is only raised on the last result of a packet.
    a_scan_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        point_out.valid && point_out.payload.scan_complete
        |-> point_out.payload.last_in_packet)
        else $error("scan_complete on a result that is not last");

    // With the result stalled and a byte waiting, no further byte is taken.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        point_out.valid && !point_out.ready && byte_valid |-> !byte_in.ready)
        else $error("input accepted while both registers are full");

    // While the result is stalled, its waiting byte holds over the next cycle.
    a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        point_out.valid && !point_out.ready && byte_valid
        |=> byte_valid && $stable(byte_data))
        else $error("waiting byte lost while the result was stalled");

endmodule

@@ rtl/lpsp_in_stage.sv @@
// ----------------------------------------------------------------------------
// LiDAR packet stream parser input stage
// Registers each accepted byte and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module lpsp_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    lpsp_stream_if.sink         byte_in,
    input  logic                advance,
    output logic                byte_valid,
    output logic [7:0]          byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // The stage takes a new byte when empty or when its byte moves on.
    assign byte_in.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_in.ready)
        begin
            valid_next = byte_in.valid;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Byte payload.
    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            data_reg <= byte_in.payload.data_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

@@ rtl/lpsp_parser.sv @@
// ----------------------------------------------------------------------------
// LiDAR packet stream parser core
// Sync hunt, header decode and point assembly with a registered result.
// ----------------------------------------------------------------------------
module lpsp_parser #(
    parameter int HEADER_BYTES = lpsp_pkg::HEADER_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          max_distance,
    input  logic [15:0]          max_intensity,
    input  logic                 byte_valid,
    input  logic [7:0]           byte_data,
    output logic                 advance,
    input  logic                 res_ready,
    output logic                 res_valid,
    output lpsp_pkg::point_item_t res_data
);

    localparam int CNT_W = $clog2(HEADER_BYTES);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_H,
        PH_HI,
        PH_HIS,
        PH_HEADER,
        PH_BODY
    } phase_t;

    phase_t               phase_reg,      phase_next;
    logic [CNT_W-1:0]     cnt_reg,        cnt_next;
    logic [15:0]          start_reg,      start_next;
    logic [15:0]          end_reg,        end_next;
    logic [15:0]          count_reg,      count_next;
    logic [15:0]          fpos_reg,       fpos_next;
    logic [15:0]          total_reg,      total_next;
    logic [15:0]          done_reg,       done_next;
    logic [7:0]           dlow_reg,       dlow_next;
    logic [15:0]          dist_reg,       dist_next;
    logic [7:0]           ilow_reg,       ilow_next;
    logic                 res_valid_reg,  res_valid_next;
    lpsp_pkg::point_item_t res_reg,       res_next;

    logic        out_free;
    logic        step;
    logic        emit;
    logic [15:0] word_v;
    logic [15:0] count_clamp;
    logic        scan_flag;
    logic [1:0]  pt_pos;

    // A byte is consumed only when the result register can take a result.
    assign out_free = !res_valid_reg || res_ready;
    assign step     = byte_valid && out_free;
    assign advance  = step;
    assign pt_pos   = cnt_reg[1:0];
    assign word_v   = {byte_data, (pt_pos == lpsp_pkg::PT_DIST_HI) ? dlow_reg : ilow_reg};

    // Next-state logic for one byte.
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        count_next  = count_reg;
        fpos_next   = fpos_reg;
        total_next  = total_reg;
        done_next   = done_reg;
        dlow_next   = dlow_reg;
        dist_next   = dist_reg;
        ilow_next   = ilow_reg;
        count_clamp = '0;
        scan_flag   = 1'b0;
        emit        = 1'b0;
        res_next    = '0;
        res_next.start_ang = start_reg;

        unique case (phase_reg)
            PH_H, PH_HI, PH_HIS:
            begin
                if (byte_data == lpsp_pkg::SYNC0)
                begin
                    phase_next = PH_H;
                end
                else if ((phase_reg == PH_H   && byte_data == lpsp_pkg::SYNC1) ||
                         (phase_reg == PH_HI  && byte_data == lpsp_pkg::SYNC2))
                begin
                    phase_next = phase_t'(phase_reg + 3'd1);
                end
                else if (phase_reg == PH_HIS && byte_data == lpsp_pkg::SYNC3)
                begin
                    phase_next = PH_HEADER;
                    cnt_next   = CNT_W'(lpsp_pkg::HDR_FIRST);
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end

            PH_HEADER:
            begin
                // Big-endian header fields, one byte at a time.
                if (cnt_reg == CNT_W'(lpsp_pkg::HDR_START_HI)) start_next[15:8] = byte_data;
                if (cnt_reg == CNT_W'(lpsp_pkg::HDR_START_LO)) start_next[7:0]  = byte_data;
                if (cnt_reg == CNT_W'(lpsp_pkg::HDR_END_HI))   end_next[15:8]   = byte_data;
                if (cnt_reg == CNT_W'(lpsp_pkg::HDR_END_LO))   end_next[7:0]    = byte_data;
                if (cnt_reg == CNT_W'(lpsp_pkg::HDR_COUNT_HI)) count_next[15:8] = byte_data;
                if (cnt_reg == CNT_W'(lpsp_pkg::HDR_COUNT_LO)) count_next[7:0]  = byte_data;
                if (cnt_reg == CNT_W'(lpsp_pkg::HDR_POS_HI))   fpos_next[15:8]  = byte_data;
                if (cnt_reg == CNT_W'(lpsp_pkg::HDR_POS_LO))   fpos_next[7:0]   = byte_data;
                if (cnt_reg == CNT_W'(lpsp_pkg::HDR_TOTAL_HI)) total_next[15:8] = byte_data;
                if (cnt_reg == CNT_W'(lpsp_pkg::HDR_TOTAL_LO)) total_next[7:0]  = byte_data;

                if (cnt_reg != CNT_W'(HEADER_BYTES - 1))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    // End of header: clamp the count, start the body or close
                    // an empty packet with a result that carries no point.
                    // Clamp and scan flag use the header as updated this byte.
                    count_clamp = (count_next > total_next) ? total_next : count_next;
                    scan_flag   = (end_next == 16'd0) && (fpos_next == total_next);
                    count_next  = count_clamp;
                    cnt_next    = '0;
                    done_next   = '0;
                    if (count_clamp == 16'd0)
                    begin
                        phase_next              = PH_HUNT;
                        emit                    = 1'b1;
                        res_next.start_ang      = start_next;
                        res_next.last_in_packet = 1'b1;
                        res_next.scan_complete  = scan_flag;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end

            PH_BODY:
            begin
                cnt_next = CNT_W'(pt_pos + 2'd1);
                unique case (pt_pos)
                    lpsp_pkg::PT_DIST_LO:
                    begin
                        dlow_next = byte_data;
                    end
                    lpsp_pkg::PT_DIST_HI:
                    begin
                        dist_next = (word_v > max_distance) ? max_distance : word_v;
                    end
                    lpsp_pkg::PT_INT_LO:
                    begin
                        ilow_next = byte_data;
                    end
                    default:
                    begin
                        // Last byte of a point: emit it.
                        done_next               = done_reg + 16'd1;
                        emit                    = 1'b1;
                        res_next.point_valid    = 1'b1;
                        res_next.distance       = dist_reg;
                        res_next.intensity      = (word_v > max_intensity) ?
                                                  max_intensity : word_v;
                        res_next.point_index    = done_reg;
                        res_next.last_in_packet = (done_next >= count_reg);
                        res_next.scan_complete  = res_next.last_in_packet &&
                                                  (end_reg == 16'd0) &&
                                                  (fpos_reg == total_reg);
                        if (res_next.last_in_packet)
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                endcase
            end

            default:
            begin
                phase_next = (byte_data == lpsp_pkg::SYNC0) ? PH_H : PH_HUNT;
            end
        endcase
    end

    // Result valid flag: set by a new result, cleared when taken.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_free)
        begin
            res_valid_next = step && emit;
        end
    end

    // Parser state, registered result flag and result payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            cnt_reg       <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            count_reg     <= '0;
            fpos_reg      <= '0;
            total_reg     <= '0;
            done_reg      <= '0;
            dlow_reg      <= '0;
            dist_reg      <= '0;
            ilow_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (step)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                start_reg <= start_next;
                end_reg   <= end_next;
                count_reg <= count_next;
                fpos_reg  <= fpos_next;
                total_reg <= total_next;
                done_reg  <= done_next;
                dlow_reg  <= dlow_next;
                dist_reg  <= dist_next;
                ilow_reg  <= ilow_next;
            end
            if (step && emit)
            begin
                res_reg <= res_next;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

@@ tb/sv/lidar_packet_stream_parser_top_tb.sv @@
// ----------------------------------------------------------------------------
// LiDAR packet stream parser testbench
// Drives scanner byte streams into the parser and checks every point result
// against a behavioral parser model: a directed table first, then random
// packets under several saturation settings, with random source gaps and
// sink stalls.
// ----------------------------------------------------------------------------
module lidar_packet_stream_parser_top_tb;

    localparam int HDR_LEN     = lpsp_pkg::HEADER_BYTES_DEF;
    localparam int QUIET_MAX   = 1000;
    localparam int PHASES      = 6;
    localparam int PHASE_BYTES = 200;
    localparam int EXP_DEPTH   = 4096;

    // Parser phases of the model.
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_H      = 3'd1,
        PH_HI     = 3'd2,
        PH_HIS    = 3'd3,
        PH_HEADER = 3'd4,
        PH_BODY   = 3'd5
    } parse_phase_t;

    // One row of the directed stimulus table.
    typedef struct {
        logic [7:0]            data;
        bit                    typed;
        lpsp_pkg::point_item_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [lpsp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lpsp_pkg::CFG_DATA_W-1:0] cfg_data;

    lpsp_stream_if #(.payload_t(lpsp_pkg::byte_item_t))  byte_ch ();
    lpsp_stream_if #(.payload_t(lpsp_pkg::point_item_t)) point_ch ();

    lidar_packet_stream_parser_top #(
        .HEADER_BYTES (HDR_LEN)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_ch.sink),
        .point_out (point_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state and register copies.
    parse_phase_t m_phase;
    logic [4:0]   m_count_pos;
    logic [15:0]  m_start;
    logic [15:0]  m_end;
    logic [15:0]  m_npoints;
    logic [15:0]  m_fpos;
    logic [15:0]  m_ftotal;
    logic [15:0]  m_done;
    logic [7:0]   m_dist_lo;
    logic [15:0]  m_dist;
    logic [7:0]   m_int_lo;
    logic [15:0]  lim_distance;
    logic [15:0]  lim_intensity;

    // Expected results, in order, as a ring with write and read counts.
    lpsp_pkg::point_item_t exp_buf [EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          err_cnt;
    int          quiet_cycles;
    bit          gaps_on;
    int          phase_bytes = 0;

    // Directed table: noise, stray sync restart, a header whose count exceeds
    // its total so the packet ends up empty, sync bytes inside the header,
    // and a broken sync word.
    dir_row_t dir_tab [23] = '{
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{lpsp_pkg::SYNC0, 1'b0, '0},
        '{lpsp_pkg::SYNC0, 1'b0, '0},
        '{lpsp_pkg::SYNC1, 1'b0, '0},
        '{lpsp_pkg::SYNC2, 1'b0, '0},
        '{lpsp_pkg::SYNC3, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{lpsp_pkg::SYNC0, 1'b0, '0},
        '{lpsp_pkg::SYNC1, 1'b1,
          '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b1}},
        '{lpsp_pkg::SYNC0, 1'b0, '0},
        '{lpsp_pkg::SYNC1, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{lpsp_pkg::SYNC2, 1'b0, '0}
    };

    // Clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic parse_phase_t sync_next(input logic [7:0] b, input logic [7:0] want);
        if (b == lpsp_pkg::SYNC0)
            return PH_H;
        if (b == want)
            return parse_phase_t'(m_phase + 3'd1);
        return PH_HUNT;
    endfunction

    function automatic logic scan_flag();
        return (m_end == 16'h0000) && (m_fpos == m_ftotal);
    endfunction

    // Appends one expected result.
    task automatic push_expected(input lpsp_pkg::point_item_t item);
        exp_buf[exp_wr % EXP_DEPTH] = item;
        exp_wr++;
    endtask

    // Behavioral parser: consumes one byte and reports the result it causes.
    task automatic parse_byte(input logic [7:0] b, output bit got,
                              output lpsp_pkg::point_item_t res);
        int          pos;
        logic [15:0] v;
        logic        last;
        got = 1'b0;
        res = '0;
        case (m_phase)
            PH_H:   m_phase = sync_next(b, lpsp_pkg::SYNC1);
            PH_HI:  m_phase = sync_next(b, lpsp_pkg::SYNC2);
            PH_HIS:
            begin
                m_phase = sync_next(b, lpsp_pkg::SYNC3);
                if (m_phase == PH_HEADER)
                    m_count_pos = 5'(lpsp_pkg::HDR_FIRST);
            end
            PH_HEADER:
            begin
                pos = int'(m_count_pos);
                case (pos)
                    lpsp_pkg::HDR_START_HI: m_start[15:8]   = b;
                    lpsp_pkg::HDR_START_LO: m_start[7:0]    = b;
                    lpsp_pkg::HDR_END_HI:   m_end[15:8]     = b;
                    lpsp_pkg::HDR_END_LO:   m_end[7:0]      = b;
                    lpsp_pkg::HDR_COUNT_HI: m_npoints[15:8] = b;
                    lpsp_pkg::HDR_COUNT_LO: m_npoints[7:0]  = b;
                    lpsp_pkg::HDR_POS_HI:   m_fpos[15:8]    = b;
                    lpsp_pkg::HDR_POS_LO:   m_fpos[7:0]     = b;
                    lpsp_pkg::HDR_TOTAL_HI: m_ftotal[15:8]  = b;
                    lpsp_pkg::HDR_TOTAL_LO: m_ftotal[7:0]   = b;
                    default: ;
                endcase
                if (pos + 1 < HDR_LEN)
                    m_count_pos = 5'(pos + 1);
                else
                begin
                    if (m_npoints > m_ftotal)
                        m_npoints = m_ftotal;
                    m_count_pos = '0;
                    m_done = '0;
                    if (m_npoints == 16'h0000)
                    begin
                        m_phase = PH_HUNT;
                        got = 1'b1;
                        res = '{1'b0, 16'h0000, 16'h0000, 16'h0000, m_start, 1'b1,
                                scan_flag()};
                    end
                    else
                        m_phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                case (m_count_pos[1:0])
                    lpsp_pkg::PT_DIST_LO:
                    begin
                        m_dist_lo = b;
                        m_count_pos = 5'd1;
                    end
                    lpsp_pkg::PT_DIST_HI:
                    begin
                        v = {b, m_dist_lo};
                        m_dist = (v > lim_distance) ? lim_distance : v;
                        m_count_pos = 5'd2;
                    end
                    lpsp_pkg::PT_INT_LO:
                    begin
                        m_int_lo = b;
                        m_count_pos = 5'd3;
                    end
                    default:
                    begin
                        v = {b, m_int_lo};
                        if (v > lim_intensity)
                            v = lim_intensity;
                        m_count_pos = '0;
                        res.point_index = m_done;
                        m_done = m_done + 16'd1;
                        last = (m_done >= m_npoints);
                        if (last)
                            m_phase = PH_HUNT;
                        got = 1'b1;
                        res.point_valid = 1'b1;
                        res.distance = m_dist;
                        res.intensity = v;
                        res.start_ang = m_start;
                        res.last_in_packet = last;
                        res.scan_complete = last ? scan_flag() : 1'b0;
                    end
                endcase
            end
            default: m_phase = (b == lpsp_pkg::SYNC0) ? PH_H : PH_HUNT;
        endcase
    endtask

    // Sends one byte, waits for its transaction, then records what it causes.
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input lpsp_pkg::point_item_t tval);
        bit                    got;
        lpsp_pkg::point_item_t res;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.payload.data_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        phase_bytes++;
        parse_byte(b, got, res);
        if (typed)
            push_expected(tval);
        else if (got)
            push_expected(res);
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    // Values biased toward the extremes and the saturation boundary.
    function automatic logic [15:0] pick_value(input logic [15:0] lim);
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return lim;
            3: return lim + 16'd1;
            4: return lim - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_noise();
        case ($urandom_range(0, 5))
            0: return lpsp_pkg::SYNC0;
            1: return lpsp_pkg::SYNC1;
            2: return lpsp_pkg::SYNC2;
            3: return lpsp_pkg::SYNC3;
            default: return 8'($urandom);
        endcase
    endfunction

    // One stretch of random stream: mostly well-formed packets, some noise
    // and some sync words broken off early.
    task automatic send_packet();
        logic [15:0] start_a, end_a, npts, fpos, ftotal, clamped, dist_val, inten;
        logic [7:0]  hdr [HDR_LEN];
        int          nbytes;
        int          kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 8)) put_byte(pick_noise());
            return;
        end
        if (kind == 1)
        begin
            put_byte(lpsp_pkg::SYNC0);
            if ($urandom_range(0, 1)) put_byte(lpsp_pkg::SYNC1);
            if ($urandom_range(0, 1)) put_byte(lpsp_pkg::SYNC2);
            put_byte(8'($urandom));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            put_byte(lpsp_pkg::SYNC0);
        put_byte(lpsp_pkg::SYNC0);
        put_byte(lpsp_pkg::SYNC1);
        put_byte(lpsp_pkg::SYNC2);
        put_byte(lpsp_pkg::SYNC3);

        start_a = pick_value(16'h8000);
        end_a = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
        case ($urandom_range(0, 7))
            0:
            begin
                npts = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
                ftotal = 16'($urandom_range(0, 4));
            end
            1:
            begin
                npts = 16'($urandom_range(0, 5));
                ftotal = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
            end
            2:
            begin
                npts = 16'h0000;
                ftotal = 16'($urandom_range(0, 3));
            end
            default:
            begin
                npts = 16'($urandom_range(1, 6));
                ftotal = npts + 16'($urandom_range(0, 3));
            end
        endcase
        fpos = ($urandom_range(0, 1)) ? ftotal : 16'($urandom);
        clamped = (npts > ftotal) ? ftotal : npts;

        hdr[lpsp_pkg::HDR_START_HI] = start_a[15:8];
        hdr[lpsp_pkg::HDR_START_LO] = start_a[7:0];
        hdr[lpsp_pkg::HDR_END_HI]   = end_a[15:8];
        hdr[lpsp_pkg::HDR_END_LO]   = end_a[7:0];
        hdr[lpsp_pkg::HDR_COUNT_HI] = npts[15:8];
        hdr[lpsp_pkg::HDR_COUNT_LO] = npts[7:0];
        hdr[lpsp_pkg::HDR_POS_HI]   = fpos[15:8];
        hdr[lpsp_pkg::HDR_POS_LO]   = fpos[7:0];
        hdr[lpsp_pkg::HDR_TOTAL_HI] = ftotal[15:8];
        hdr[lpsp_pkg::HDR_TOTAL_LO] = ftotal[7:0];
        for (int i = lpsp_pkg::HDR_TOTAL_LO + 1; i < HDR_LEN; i++)
            hdr[i] = pick_noise();
        for (int i = lpsp_pkg::HDR_FIRST; i < HDR_LEN; i++)
            put_byte(hdr[i]);

        // Occasionally cut the body short so the next bytes land in it.
        nbytes = int'(clamped) * 4;
        if ($urandom_range(0, 15) == 0)
            nbytes = $urandom_range(0, nbytes);
        dist_val = '0;
        inten = '0;
        for (int j = 0; j < nbytes; j++)
        begin
            if (j % 4 == 0)
            begin
                dist_val = pick_value(lim_distance);
                inten = pick_value(lim_intensity);
            end
            case (j % 4)
                0: put_byte(dist_val[7:0]);
                1: put_byte(dist_val[15:8]);
                2: put_byte(inten[7:0]);
                default: put_byte(inten[15:8]);
            endcase
        end
    endtask

    // Writes both saturation registers, distance first, then intensity.
    task automatic set_limits(input logic [15:0] dmax, input logic [15:0] imax);
        cfg_we <= 1'b1;
        cfg_index <= lpsp_pkg::CFG_MAX_DISTANCE;
        cfg_data <= dmax;
        @(posedge clk);
        lim_distance = dmax;
        cfg_index <= lpsp_pkg::CFG_MAX_INTENSITY;
        cfg_data <= imax;
        @(posedge clk);
        lim_intensity = imax;
        cfg_we <= 1'b0;
    endtask

    // Stops the source and lets the parser settle with nothing pending.
    task automatic drain();
        byte_ch.valid <= 1'b0;
        while ((exp_wr - exp_rd) != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Result checker.
    always @(posedge clk)
    begin : result_check
        lpsp_pkg::point_item_t want;
        if (rst_n && point_ch.valid && point_ch.ready)
        begin
            if ((exp_wr - exp_rd) == 0)
            begin
                $error("point_out: transaction with no result pending");
                err_cnt++;
            end
            else
            begin
                want = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                compare_field("point_valid", 16'(want.point_valid),
                              16'(point_ch.payload.point_valid));
                compare_field("distance", want.distance, point_ch.payload.distance);
                compare_field("intensity", want.intensity, point_ch.payload.intensity);
                compare_field("point_index", want.point_index, point_ch.payload.point_index);
                compare_field("start_ang", want.start_ang, point_ch.payload.start_ang);
                compare_field("last_in_packet", 16'(want.last_in_packet),
                              16'(point_ch.payload.last_in_packet));
                compare_field("scan_complete", 16'(want.scan_complete),
                              16'(point_ch.payload.scan_complete));
            end
        end
    end

    // Watchdog on stretches with no transaction on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (point_ch.valid && point_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result sink with random stall bursts and stall-free stretches.
    initial
    begin
        point_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (gaps_on && $urandom_range(0, 15) == 0)
            begin
                repeat ($urandom_range(20, 80))
                begin
                    point_ch.ready <= 1'b1;
                    @(posedge clk);
                end
            end
            if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                point_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            point_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Main sequence.
    initial
    begin
        logic [15:0] dmax_tab [PHASES];
        logic [15:0] imax_tab [PHASES];
        rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.payload <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        err_cnt = 0;
        quiet_cycles = 0;
        gaps_on = 1'b1;
        m_phase = PH_HUNT;
        m_count_pos = '0;
        m_start = '0;
        m_end = '0;
        m_npoints = '0;
        m_fpos = '0;
        m_ftotal = '0;
        m_done = '0;
        m_dist_lo = '0;
        m_dist = '0;
        m_int_lo = '0;
        lim_distance = 16'hFFFF;
        lim_intensity = 16'hFFFF;

        dmax_tab = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h8000, 16'hFFFF, 16'($urandom)};
        imax_tab = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h00FF, 16'h0000, 16'hFFFF};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, run with the reset maxima.
        foreach (dir_tab[i])
            send_byte(dir_tab[i].data, dir_tab[i].typed, dir_tab[i].want);

        // Random packets under each saturation setting; the last phase runs
        // without gaps or stalls.
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            set_limits(dmax_tab[p], imax_tab[p]);
            gaps_on = (p != PHASES - 1);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
                send_packet();
        end

        drain();
        repeat (8) @(posedge clk);
        if (err_cnt == 0 && (exp_wr - exp_rd) == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lpsp_pkg.sv
rtl/lpsp_stream_if.sv
rtl/lpsp_in_stage.sv
rtl/lpsp_parser.sv
rtl/lidar_packet_stream_parser_top.sv
tb/sv/lidar_packet_stream_parser_top_tb.sv
